>>> src/vrap_pkg.sv
// ----------------------------------------------------------------------------
// vrap_pkg
// Shared types and constants for the point rotation pipeline: the CORDIC
// datapath word, the quadrant code and the arctangent table.
// ----------------------------------------------------------------------------
package vrap_pkg;

  // Binary angle width: 65536 counts are one full turn.
  localparam int ANGLE_W   = 16;
  // CORDIC datapath width and fraction bits of cos and sin.
  localparam int CORDIC_W  = 32;
  localparam int FRAC_BITS = 28;
  // Depth of the atan table; users must keep stages within it, unchecked.
  localparam int ATAN_DEPTH = 32;

  // Inverse CORDIC gain 0.60725293 in Q.28, loaded as the start vector.
  localparam logic signed [CORDIC_W-1:0] GAIN_Q28 = 32'sd163008219;
  // 1.0 in Q.28, used when the residual angle is exactly zero.
  localparam logic signed [CORDIC_W-1:0] COS_ONE  = 32'sd268435456;

  // Arctangent of 2^-i in units of 2^32 counts per turn, truncated.
  localparam logic signed [CORDIC_W-1:0] ATAN_TAB [ATAN_DEPTH] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
    32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
    32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
    32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9, 32'sh0000517C,
    32'sh000028BE, 32'sh0000145F, 32'sh00000A2F, 32'sh00000517,
    32'sh0000028B, 32'sh00000145, 32'sh000000A2, 32'sh00000051,
    32'sh00000028, 32'sh00000014, 32'sh0000000A, 32'sh00000005,
    32'sh00000002, 32'sh00000001, 32'sh00000000, 32'sh00000000
  };

  // Quarter turn that is taken out of the angle before the CORDIC.
  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quadrant_t;

  // CORDIC vector and residual angle.
  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
  } cordic_t;

endpackage

>>> src/vrap_if.sv
// ----------------------------------------------------------------------------
// vrap_in_if / vrap_out_if
// Valid/ready channels that carry one input item and one result item.
// ----------------------------------------------------------------------------
interface vrap_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                               valid;
  logic                               ready;
  logic signed [COORD_WIDTH-1:0]      point_x;
  logic signed [COORD_WIDTH-1:0]      point_y;
  logic signed [COORD_WIDTH-1:0]      pivot_x;
  logic signed [COORD_WIDTH-1:0]      pivot_y;
  logic [vrap_pkg::ANGLE_W-1:0]       turn_angle;

  modport source (output valid, point_x, point_y, pivot_x, pivot_y, turn_angle,
                  input ready);
  modport sink   (input valid, point_x, point_y, pivot_x, pivot_y, turn_angle,
                  output ready);
endinterface

interface vrap_out_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] rotated_x;
  logic signed [COORD_WIDTH-1:0] rotated_y;
  logic                          overflow;

  modport source (output valid, rotated_x, rotated_y, overflow, input ready);
  modport sink   (input valid, rotated_x, rotated_y, overflow, output ready);
endinterface

>>> src/vrap_prep.sv
// ----------------------------------------------------------------------------
// vrap_prep
// First pipeline stage: offsets from the pivot, quadrant split of the angle
// and the CORDIC start vector.
// ----------------------------------------------------------------------------
module vrap_prep #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [COORD_WIDTH-1:0]       point_x,
  input  logic signed [COORD_WIDTH-1:0]       point_y,
  input  logic signed [COORD_WIDTH-1:0]       pivot_x,
  input  logic signed [COORD_WIDTH-1:0]       pivot_y,
  input  logic [vrap_pkg::ANGLE_W-1:0]        turn_angle,
  output logic                                out_valid,
  output vrap_pkg::cordic_t                   out_st,
  output vrap_pkg::quadrant_t                 out_quad,
  output logic                                out_zero,
  output logic signed [COORD_WIDTH:0]         out_dx,
  output logic signed [COORD_WIDTH:0]         out_dy,
  output logic signed [COORD_WIDTH-1:0]       out_pvx,
  output logic signed [COORD_WIDTH-1:0]       out_pvy
);

  localparam int AW = vrap_pkg::ANGLE_W;
  localparam int CW = vrap_pkg::CORDIC_W;

  logic [AW-1:0]                   shifted;
  logic [AW-1:0]                   resid;
  vrap_pkg::quadrant_t             quad_nxt;
  vrap_pkg::cordic_t               st_nxt;

  logic                            valid_r;
  vrap_pkg::cordic_t               st_r;
  vrap_pkg::quadrant_t             quad_r;
  logic                            zero_r;
  logic signed [COORD_WIDTH:0]     dx_r;
  logic signed [COORD_WIDTH:0]     dy_r;
  logic signed [COORD_WIDTH-1:0]   pvx_r;
  logic signed [COORD_WIDTH-1:0]   pvy_r;

  // The nearest quarter turn is removed; the residual lies in [-45, +45) degrees.
  always_comb begin
    shifted  = turn_angle + AW'(16'd8192);
    quad_nxt = vrap_pkg::quadrant_t'(shifted[AW-1:AW-2]);
    resid    = turn_angle - {shifted[AW-1:AW-2], {(AW-2){1'b0}}};
    st_nxt.x = vrap_pkg::GAIN_Q28;
    st_nxt.y = '0;
    st_nxt.z = {resid, {(CW-AW){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r   <= st_nxt;
      quad_r <= quad_nxt;
      zero_r <= (resid == '0);
      dx_r   <= (COORD_WIDTH+1)'(point_x) - (COORD_WIDTH+1)'(pivot_x);
      dy_r   <= (COORD_WIDTH+1)'(point_y) - (COORD_WIDTH+1)'(pivot_y);
      pvx_r  <= pivot_x;
      pvy_r  <= pivot_y;
    end
  end

  assign out_valid = valid_r;
  assign out_st    = st_r;
  assign out_quad  = quad_r;
  assign out_zero  = zero_r;
  assign out_dx    = dx_r;
  assign out_dy    = dy_r;
  assign out_pvx   = pvx_r;
  assign out_pvy   = pvy_r;

endmodule

>>> src/vrap_cordic_stage.sv
// ----------------------------------------------------------------------------
// vrap_cordic_stage
// One rotation-mode CORDIC iteration with its own pipeline register.
// ----------------------------------------------------------------------------
module vrap_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  vrap_pkg::cordic_t in_st,
  output logic              out_valid,
  output vrap_pkg::cordic_t out_st
);

  localparam int CW = vrap_pkg::CORDIC_W;
  localparam logic signed [CW-1:0] ATAN = vrap_pkg::ATAN_TAB[SHIFT];

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [CW-1:0] z;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  vrap_pkg::cordic_t    st_nxt;

  logic                 valid_r;
  vrap_pkg::cordic_t    st_r;

  // Arithmetic shifts floor toward minus infinity, matching the model.
  always_comb begin
    x  = in_st.x;
    y  = in_st.y;
    z  = in_st.z;
    xs = x >>> SHIFT;
    ys = y >>> SHIFT;
    if (!z[CW-1]) begin
      st_nxt.x = x - ys;
      st_nxt.y = y + xs;
      st_nxt.z = z - ATAN;
    end else begin
      st_nxt.x = x + ys;
      st_nxt.y = y - xs;
      st_nxt.z = z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_st    = st_r;

endmodule

>>> src/vrap_out.sv
// ----------------------------------------------------------------------------
// vrap_out
// Back end of the pipeline: quadrant mapping of cos and sin, the four
// products, rounding plus pivot, and saturation into the output register.
// ----------------------------------------------------------------------------
module vrap_out #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  vrap_pkg::cordic_t             in_st,
  input  vrap_pkg::quadrant_t           in_quad,
  input  logic                          in_zero,
  input  logic signed [COORD_WIDTH:0]   in_dx,
  input  logic signed [COORD_WIDTH:0]   in_dy,
  input  logic signed [COORD_WIDTH-1:0] in_pvx,
  input  logic signed [COORD_WIDTH-1:0] in_pvy,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic                          out_ovf
);

  localparam int CW  = vrap_pkg::CORDIC_W;
  localparam int FB  = vrap_pkg::FRAC_BITS;
  localparam int DW  = COORD_WIDTH + 1;
  localparam int MW  = DW + CW;
  localparam int PW  = MW + 1;
  localparam int OW  = PW - FB;
  localparam int SW  = OW + 1;
  localparam logic signed [PW-1:0] ROUND_HALF =
    {{(PW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
  localparam logic signed [SW-1:0] SAT_HI =
    {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  // Stage 1: cos and sin of the full angle.
  logic signed [CW-1:0]          c_base;
  logic signed [CW-1:0]          s_base;
  logic signed [CW-1:0]          cos_nxt;
  logic signed [CW-1:0]          sin_nxt;
  logic                          v1_r;
  logic signed [CW-1:0]          cos_r;
  logic signed [CW-1:0]          sin_r;
  logic signed [DW-1:0]          dx1_r;
  logic signed [DW-1:0]          dy1_r;
  logic signed [COORD_WIDTH-1:0] pvx1_r;
  logic signed [COORD_WIDTH-1:0] pvy1_r;

  always_comb begin
    c_base = in_zero ? vrap_pkg::COS_ONE : in_st.x;
    s_base = in_zero ? '0 : in_st.y;
    unique case (in_quad)
      vrap_pkg::QUAD_0: begin
        cos_nxt = c_base;
        sin_nxt = s_base;
      end
      vrap_pkg::QUAD_90: begin
        cos_nxt = -s_base;
        sin_nxt = c_base;
      end
      vrap_pkg::QUAD_180: begin
        cos_nxt = -c_base;
        sin_nxt = -s_base;
      end
      vrap_pkg::QUAD_270: begin
        cos_nxt = s_base;
        sin_nxt = -c_base;
      end
      default: begin
        cos_nxt = c_base;
        sin_nxt = s_base;
      end
    endcase
  end

  // Stage 2: four products of the offsets with cos and sin.
  logic                          v2_r;
  logic signed [MW-1:0]          xc_r;
  logic signed [MW-1:0]          ys_r;
  logic signed [MW-1:0]          xs_r;
  logic signed [MW-1:0]          yc_r;
  logic signed [COORD_WIDTH-1:0] pvx2_r;
  logic signed [COORD_WIDTH-1:0] pvy2_r;

  // Stage 3: combine, round to Q8.8 and add the pivot back.
  logic signed [PW-1:0]          sum_x;
  logic signed [PW-1:0]          sum_y;
  logic signed [OW-1:0]          ofs_x;
  logic signed [OW-1:0]          ofs_y;
  logic                          v3_r;
  logic signed [SW-1:0]          nx_r;
  logic signed [SW-1:0]          ny_r;

  always_comb begin
    sum_x = PW'(xc_r) - PW'(ys_r) + ROUND_HALF;
    sum_y = PW'(xs_r) + PW'(yc_r) + ROUND_HALF;
    ofs_x = sum_x[PW-1:FB];
    ofs_y = sum_y[PW-1:FB];
  end

  // Stage 4: saturation into the output register.
  logic                          hi_x;
  logic                          lo_x;
  logic                          hi_y;
  logic                          lo_y;
  logic                          v4_r;
  logic signed [COORD_WIDTH-1:0] x4_r;
  logic signed [COORD_WIDTH-1:0] y4_r;
  logic                          ovf4_r;

  always_comb begin
    hi_x = nx_r > SAT_HI;
    lo_x = nx_r < SAT_LO;
    hi_y = ny_r > SAT_HI;
    lo_y = ny_r < SAT_LO;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r  <= cos_nxt;
      sin_r  <= sin_nxt;
      dx1_r  <= in_dx;
      dy1_r  <= in_dy;
      pvx1_r <= in_pvx;
      pvy1_r <= in_pvy;

      xc_r   <= MW'(dx1_r) * MW'(cos_r);
      ys_r   <= MW'(dy1_r) * MW'(sin_r);
      xs_r   <= MW'(dx1_r) * MW'(sin_r);
      yc_r   <= MW'(dy1_r) * MW'(cos_r);
      pvx2_r <= pvx1_r;
      pvy2_r <= pvy1_r;

      nx_r   <= SW'(ofs_x) + SW'(pvx2_r);
      ny_r   <= SW'(ofs_y) + SW'(pvy2_r);

      x4_r   <= hi_x ? SAT_HI[COORD_WIDTH-1:0] :
                lo_x ? SAT_LO[COORD_WIDTH-1:0] : nx_r[COORD_WIDTH-1:0];
      y4_r   <= hi_y ? SAT_HI[COORD_WIDTH-1:0] :
                lo_y ? SAT_LO[COORD_WIDTH-1:0] : ny_r[COORD_WIDTH-1:0];
      ovf4_r <= hi_x | lo_x | hi_y | lo_y;
    end
  end

  assign out_valid = v4_r;
  assign out_x     = x4_r;
  assign out_y     = y4_r;
  assign out_ovf   = ovf4_r;

endmodule

>>> src/vector_rotate_about_point.sv
// ----------------------------------------------------------------------------
// vector_rotate_about_point
// Rotates a signed Q8.8 point about a pivot by a binary angle using an
// unrolled CORDIC pipeline, with rounding and saturation of the result.
// ----------------------------------------------------------------------------
// Usage: an item on in_ch carries point, pivot and a counter-clockwise angle
// (65536 counts per turn). Each item yields exactly one result item on out_ch
// with the rotated point and an overflow flag that is set when either
// coordinate had to be clamped to the signed COORD_WIDTH range.
// Stages: one prep stage, one stage per CORDIC iteration, then mapping,
// multiply, round/add and saturate stages, the last of which is the
// output register. Throughput is one item per cycle while out_ch.ready
// is high; the unrolled CORDIC chain takes a new item at every clock edge
// that it advances, so the whole pipeline runs at full rate unless stalled.
// Reset (rst_n low, synchronous) clears every valid bit; the pipeline comes
// up empty and ready. When the receiver stalls while a result is waiting,
// the whole pipeline freezes in place and in_ch.ready drops in the same
// cycle, so nothing is lost or repeated; it moves on as soon as out_ch.ready
// returns. While the output register is empty, bubbles keep flowing.
// ----------------------------------------------------------------------------
module vector_rotate_about_point #(
  parameter int COORD_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  vrap_in_if.sink           in_ch,
  vrap_out_if.source        out_ch
);

  // Side data that rides along the CORDIC chain: offsets, pivot, quadrant
  // and the zero-residual flag.
  localparam int SIDE_W = 2 * (COORD_WIDTH + 1) + 2 * COORD_WIDTH + 2 + 1;

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX =
    {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = ~COORD_MAX;

  // The pipeline advances as one unit whenever the output register is free
  // or is being emptied in this cycle.
  logic advance;
  assign advance     = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = advance;

  logic                          prep_valid;
  vrap_pkg::cordic_t             prep_st;
  vrap_pkg::quadrant_t           prep_quad;
  logic                          prep_zero;
  logic signed [COORD_WIDTH:0]   prep_dx;
  logic signed [COORD_WIDTH:0]   prep_dy;
  logic signed [COORD_WIDTH-1:0] prep_pvx;
  logic signed [COORD_WIDTH-1:0] prep_pvy;

  vrap_prep #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (advance),
    .in_valid   (in_ch.valid),
    .point_x    (in_ch.point_x),
    .point_y    (in_ch.point_y),
    .pivot_x    (in_ch.pivot_x),
    .pivot_y    (in_ch.pivot_y),
    .turn_angle (in_ch.turn_angle),
    .out_valid  (prep_valid),
    .out_st     (prep_st),
    .out_quad   (prep_quad),
    .out_zero   (prep_zero),
    .out_dx     (prep_dx),
    .out_dy     (prep_dy),
    .out_pvx    (prep_pvx),
    .out_pvy    (prep_pvy)
  );

  // CORDIC chain: stage g applies the 2^-g micro-rotation.
  logic              chain_valid [CORDIC_STAGES+1];
  vrap_pkg::cordic_t chain_st    [CORDIC_STAGES+1];

  assign chain_valid[0] = prep_valid;
  assign chain_st[0]    = prep_st;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    vrap_cordic_stage #(
      .SHIFT (g)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (advance),
      .in_valid  (chain_valid[g]),
      .in_st     (chain_st[g]),
      .out_valid (chain_valid[g+1]),
      .out_st    (chain_st[g+1])
    );
  end

  // Delay line for the side data, one tap per CORDIC stage.
  logic [SIDE_W-1:0] side_in;
  logic [SIDE_W-1:0] side_r [CORDIC_STAGES];

  assign side_in = {prep_dx, prep_dy, prep_pvx, prep_pvy, prep_quad, prep_zero};

  always_ff @(posedge clk) begin
    if (advance) begin
      side_r[0] <= side_in;
      for (int i = 1; i < CORDIC_STAGES; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  logic signed [COORD_WIDTH:0]   side_dx;
  logic signed [COORD_WIDTH:0]   side_dy;
  logic signed [COORD_WIDTH-1:0] side_pvx;
  logic signed [COORD_WIDTH-1:0] side_pvy;
  logic [1:0]                    side_quad_bits;
  logic                          side_zero;

  assign {side_dx, side_dy, side_pvx, side_pvy, side_quad_bits, side_zero} =
    side_r[CORDIC_STAGES-1];

  vrap_out #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .in_valid  (chain_valid[CORDIC_STAGES]),
    .in_st     (chain_st[CORDIC_STAGES]),
    .in_quad   (vrap_pkg::quadrant_t'(side_quad_bits)),
    .in_zero   (side_zero),
    .in_dx     (side_dx),
    .in_dy     (side_dy),
    .in_pvx    (side_pvx),
    .in_pvy    (side_pvy),
    .out_valid (out_ch.valid),
    .out_x     (out_ch.rotated_x),
    .out_y     (out_ch.rotated_y),
    .out_ovf   (out_ch.overflow)
  );

  // A waiting result that is not taken must hold off new items.
  a_stall_blocks_input: assert property (
    @(posedge clk) disable iff (!rst_n)
      out_ch.valid && !out_ch.ready |-> !in_ch.ready
  ) else $error("input accepted while a result is stalled");

  // The overflow flag only comes with a coordinate clamped to a range limit.
  a_overflow_at_limit: assert property (
    @(posedge clk) disable iff (!rst_n)
      out_ch.valid && out_ch.overflow |->
        (out_ch.rotated_x == COORD_MAX) || (out_ch.rotated_x == COORD_MIN) ||
        (out_ch.rotated_y == COORD_MAX) || (out_ch.rotated_y == COORD_MIN)
  ) else $error("overflow flagged without a saturated coordinate");

  // Reset empties the pipeline, so no result follows it.
  a_reset_empties: assert property (
    @(posedge clk) !rst_n |=> !out_ch.valid
  ) else $error("result presented right after reset");

endmodule

>>> tb/vrap_rotation_checker.sv
// ----------------------------------------------------------------------------
// vrap_rotation_checker
// Watches both channels of the point rotation block. It predicts each rotated
// point from the accepted input items and compares the results in order.
// ----------------------------------------------------------------------------
module vrap_rotation_checker #(
  parameter int COORD_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst_n,
  vrap_in_if   in_ch,
  vrap_out_if  out_ch,
  output int   error_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint COORD_MAX    = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN    = -COORD_MAX - 1;
  localparam longint ROUND_HALF   = longint'(1) <<< (vrap_pkg::FRAC_BITS - 1);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] rotated_x;
    logic signed [COORD_WIDTH-1:0] rotated_y;
    logic                          overflow;
  } rotation_t;

  rotation_t pending_rotations[$];
  int        mismatches;

  // Clamps one coordinate to the signed range and notes any clamping.
  function automatic longint clamp_coord(input longint v, inout logic clamped);
    if (v > COORD_MAX) begin
      clamped = 1'b1;
      return COORD_MAX;
    end
    if (v < COORD_MIN) begin
      clamped = 1'b1;
      return COORD_MIN;
    end
    return v;
  endfunction

  // Rotates the point about the pivot: quadrant fold, CORDIC on the residual
  // angle, Q.28 products rounded to Q8.8, then saturation.
  function automatic rotation_t rotate_about_pivot(
    input logic signed [COORD_WIDTH-1:0] pt_x,
    input logic signed [COORD_WIDTH-1:0] pt_y,
    input logic signed [COORD_WIDTH-1:0] pv_x,
    input logic signed [COORD_WIDTH-1:0] pv_y,
    input logic [vrap_pkg::ANGLE_W-1:0]  angle
  );
    rotation_t           res;
    vrap_pkg::quadrant_t quad;
    int                  quad_idx;
    int                  resid;
    longint              dx, dy, cx, cy;
    longint              xr, yr, zr, xs, ys;
    longint              cos_v, sin_v, nx, ny;
    logic                clamped;

    cx       = longint'(pv_x);
    cy       = longint'(pv_y);
    dx       = longint'(pt_x) - cx;
    dy       = longint'(pt_y) - cy;
    quad_idx = ((int'(angle) + 8192) >> 14) & 3;
    quad     = vrap_pkg::quadrant_t'(quad_idx[1:0]);
    resid    = ((int'(angle) - quad_idx * 16384 + 32768) & 'hFFFF) - 32768;

    if (resid == 0) begin
      // A whole number of quarter turns is exact: the CORDIC is skipped.
      xr = longint'(vrap_pkg::COS_ONE);
      yr = 0;
    end else begin
      xr = longint'(vrap_pkg::GAIN_Q28);
      yr = 0;
      zr = longint'(resid) * 65536;
      for (int i = 0; i < CORDIC_STAGES && i < vrap_pkg::ATAN_DEPTH; i++) begin
        xs = xr >>> i;
        ys = yr >>> i;
        if (zr >= 0) begin
          xr = xr - ys;
          yr = yr + xs;
          zr = zr - longint'(vrap_pkg::ATAN_TAB[i]);
        end else begin
          xr = xr + ys;
          yr = yr - xs;
          zr = zr + longint'(vrap_pkg::ATAN_TAB[i]);
        end
      end
    end

    case (quad)
      vrap_pkg::QUAD_0: begin
        cos_v = xr;
        sin_v = yr;
      end
      vrap_pkg::QUAD_90: begin
        cos_v = -yr;
        sin_v = xr;
      end
      vrap_pkg::QUAD_180: begin
        cos_v = -xr;
        sin_v = -yr;
      end
      default: begin
        cos_v = yr;
        sin_v = -xr;
      end
    endcase

    nx      = ((dx * cos_v - dy * sin_v + ROUND_HALF) >>> vrap_pkg::FRAC_BITS) + cx;
    ny      = ((dx * sin_v + dy * cos_v + ROUND_HALF) >>> vrap_pkg::FRAC_BITS) + cy;
    clamped = 1'b0;
    nx      = clamp_coord(nx, clamped);
    ny      = clamp_coord(ny, clamped);

    res.rotated_x = COORD_WIDTH'(nx);
    res.rotated_y = COORD_WIDTH'(ny);
    res.overflow  = clamped;
    return res;
  endfunction

  // Results are checked before the new input item is queued; with the
  // pipeline latency the two can never refer to the same item anyway.
  always @(posedge clk) begin
    rotation_t want;
    rotation_t got;

    if (rst_n) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.rotated_x = out_ch.rotated_x;
        got.rotated_y = out_ch.rotated_y;
        got.overflow  = out_ch.overflow;
        if (pending_rotations.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result x=%0d y=%0d ovf=%b", $time,
                   got.rotated_x, got.rotated_y, got.overflow);
        end else begin
          want = pending_rotations.pop_front();
          if (got.rotated_x !== want.rotated_x || got.rotated_y !== want.rotated_y ||
              got.overflow !== want.overflow) begin
            mismatches++;
            $display("%0t: mismatch expected x=%0d y=%0d ovf=%b, got x=%0d y=%0d ovf=%b",
                     $time, want.rotated_x, want.rotated_y, want.overflow,
                     got.rotated_x, got.rotated_y, got.overflow);
          end
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        pending_rotations.push_back(rotate_about_pivot(in_ch.point_x, in_ch.point_y,
                                                       in_ch.pivot_x, in_ch.pivot_y,
                                                       in_ch.turn_angle));
    end
    error_count <= mismatches;
    outstanding <= pending_rotations.size();
  end

endmodule

>>> tb/tb_vector_rotate_about_point.sv
// ----------------------------------------------------------------------------
// tb_vector_rotate_about_point
// Drives point/pivot/angle items into the rotation block in random bursts
// while the result side stalls on its own pattern. A checker beside the block
// predicts every rotated point; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_vector_rotate_about_point;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;
  // The pipeline holds CORDIC_STAGES + 5 items; the drain covers that and more.
  localparam int DRAIN_CYCLES  = CORDIC_STAGES + 5 + 20;
  // Far above the length of the slowest legal run.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 1400;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct {
    coord_t                       point_x;
    coord_t                       point_y;
    coord_t                       pivot_x;
    coord_t                       pivot_y;
    logic [vrap_pkg::ANGLE_W-1:0] turn_angle;
  } rotate_job_t;

  logic clk;
  logic rst_n;
  int   error_count;
  int   outstanding;
  int   cycle_count;
  int   burst_left;

  vrap_in_if  #(.COORD_WIDTH(COORD_WIDTH)) in_ch ();
  vrap_out_if #(.COORD_WIDTH(COORD_WIDTH)) out_ch ();

  vector_rotate_about_point #(
    .COORD_WIDTH   (COORD_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  vrap_rotation_checker #(
    .COORD_WIDTH   (COORD_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  // 2 ns clock: one ns high, one ns low.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog. A lost or stuck item keeps the checker waiting forever, so a
  // hang ends here as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** vector_rotate_about_point: FAILED **");
      $finish;
    end
  end

  function automatic rotate_job_t make_job(input int px, input int py, input int cx,
                                           input int cy, input int ang);
    rotate_job_t j;
    j.point_x    = COORD_WIDTH'(px);
    j.point_y    = COORD_WIDTH'(py);
    j.pivot_x    = COORD_WIDTH'(cx);
    j.pivot_y    = COORD_WIDTH'(cy);
    j.turn_angle = vrap_pkg::ANGLE_W'(ang);
    return j;
  endfunction

  // Coordinates drawn mostly at random, with the edges of the range and the
  // values around zero picked often enough to matter.
  function automatic int edge_coord();
    case ($urandom_range(0, 5))
      0:       return 32767;
      1:       return -32768;
      2:       return 0;
      3:       return -1;
      4:       return $urandom_range(0, 511) - 256;
      default: return int'($urandom());
    endcase
  endfunction

  // Random item. Plain random geometry has the largest share; the rest aims at
  // edge values, at points close to the pivot, at angles straddling the octant
  // boundaries where the quadrant fold changes, and at exact quarter turns.
  function automatic rotate_job_t random_job();
    rotate_job_t j;
    int          kind;
    int          cx;
    int          cy;
    kind = $urandom_range(0, 99);
    cx   = int'($urandom());
    cy   = int'($urandom());
    j    = make_job(int'($urandom()), int'($urandom()), cx, cy, int'($urandom()));
    if (kind < 35) begin
      // Fully random fields, already set.
    end else if (kind < 50) begin
      j = make_job(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                   int'($urandom()));
    end else if (kind < 70) begin
      j.point_x = COORD_WIDTH'(cx + $urandom_range(0, 8192) - 4096);
      j.point_y = COORD_WIDTH'(cy + $urandom_range(0, 8192) - 4096);
    end else if (kind < 88) begin
      j.turn_angle = vrap_pkg::ANGLE_W'(8192 * $urandom_range(0, 7) +
                                        $urandom_range(0, 8) - 4);
    end else begin
      j.turn_angle = vrap_pkg::ANGLE_W'(16384 * $urandom_range(0, 3));
    end
    return j;
  endfunction

  // Presents one item and holds it until the block takes it. Before a new
  // burst the sender idles for a random gap, with junk on the payload so
  // that fields without valid are seen to be ignored. A gap of zero lets
  // bursts run together into longer stretches without idling.
  task automatic send_job(input rotate_job_t j);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid      <= 1'b0;
        in_ch.point_x    <= COORD_WIDTH'($urandom());
        in_ch.point_y    <= COORD_WIDTH'($urandom());
        in_ch.pivot_x    <= COORD_WIDTH'($urandom());
        in_ch.pivot_y    <= COORD_WIDTH'($urandom());
        in_ch.turn_angle <= vrap_pkg::ANGLE_W'($urandom());
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.point_x    <= j.point_x;
    in_ch.point_y    <= j.point_y;
    in_ch.pivot_x    <= j.pivot_x;
    in_ch.pivot_y    <= j.pivot_y;
    in_ch.turn_angle <= j.turn_angle;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Result side. A stall pattern is picked afresh for every stretch:
  // always ready, coin flips, periodic ready, or mostly stalled.
  // The mostly stalled pattern backs the pipeline up into in_ch.ready.
  initial begin
    int mode;
    int stretch;
    int phase;
    out_ch.ready = 1'b0;
    stretch      = 0;
    phase        = 0;
    mode         = 0;
    forever begin
      @(negedge clk);
      if (stretch == 0) begin
        mode    = $urandom_range(0, 3);
        stretch = $urandom_range(20, 80);
      end
      stretch--;
      phase++;
      case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        2:       out_ch.ready <= (phase % 3 == 0);
        default: out_ch.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Main sequence: reset, directed items, random items, drain, verdict.
  initial begin
    rotate_job_t directed[$];

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.point_x    = '0;
    in_ch.point_y    = '0;
    in_ch.pivot_x    = '0;
    in_ch.pivot_y    = '0;
    in_ch.turn_angle = '0;
    burst_left       = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Everything at zero, and exact quarter turns of a far-out point about
    // the origin: these skip the CORDIC and must come out exactly.
    directed.push_back(make_job(0, 0, 0, 0, 0));
    directed.push_back(make_job(32767, -32768, 0, 0, 0));
    directed.push_back(make_job(32767, -32768, 0, 0, 16384));
    directed.push_back(make_job(32767, -32768, 0, 0, 32768));
    directed.push_back(make_job(32767, -32768, 0, 0, 49152));
    directed.push_back(make_job(-32768, 32767, 0, 0, 16384));
    // Half turn of a point at one corner about the opposite corner: the
    // offset needs the extra bit and both coordinates saturate.
    directed.push_back(make_job(-32768, -32768, 32767, 32767, 32768));
    directed.push_back(make_job(32767, 32767, -32768, -32768, 32768));
    // Octant boundaries of the quadrant fold, the first two from both sides.
    directed.push_back(make_job(256, 0, 0, 0, 8191));
    directed.push_back(make_job(256, 0, 0, 0, 8192));
    directed.push_back(make_job(256, 0, 0, 0, 24575));
    directed.push_back(make_job(256, 0, 0, 0, 24576));
    directed.push_back(make_job(256, 0, 0, 0, 40960));
    directed.push_back(make_job(256, 0, 0, 0, 57344));
    // Smallest nonzero angles in either direction.
    directed.push_back(make_job(1000, -1000, 0, 0, 1));
    directed.push_back(make_job(1000, -1000, 0, 0, 65535));
    // A large point at 45 degrees: the rotated offset leaves the range on
    // one axis only, once positive and once negative.
    directed.push_back(make_job(32767, 32767, 0, 0, 8192));
    directed.push_back(make_job(-32768, -32768, 0, 0, 8192));
    // Point on the pivot stays on the pivot, at the range edges too.
    directed.push_back(make_job(-32768, 32767, -32768, 32767, 12345));
    directed.push_back(make_job(777, -4321, 777, -4321, 50000));
    // Rotation about a non-zero pivot with ordinary values.
    directed.push_back(make_job(1280, 512, -768, 2048, 5461));
    directed.push_back(make_job(-3000, 9000, 4000, -2000, 30000));

    foreach (directed[k]) send_job(directed[k]);
    repeat (RANDOM_ITEMS) send_job(random_job());

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Wait for every predicted result, then give the pipeline time to show
    // any result that was never asked for.
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("** vector_rotate_about_point: PASSED **");
    end else begin
      $display("** vector_rotate_about_point: FAILED **");
    end
    $finish;
  end

endmodule
